// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_marker;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [3:0] error_code;
        logic       last;
    } t_out;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_NO_QUOTE  = 4'd1;
    localparam logic [3:0] ERR_CONTROL   = 4'd2;
    localparam logic [3:0] ERR_ESCAPE    = 4'd3;
    localparam logic [3:0] ERR_HEX       = 4'd4;
    localparam logic [3:0] ERR_NO_LOW    = 4'd5;
    localparam logic [3:0] ERR_BAD_LOW   = 4'd6;
    localparam logic [3:0] ERR_LONE_LOW  = 4'd7;
    localparam logic [3:0] ERR_UTF8      = 4'd8;
    localparam logic [3:0] ERR_UNTERM    = 4'd9;
    localparam logic [3:0] ERR_SHORT_ESC = 4'd10;
    localparam logic [3:0] ERR_SHORT_HEX = 4'd11;

    // work handed from the decoder to the output side
    typedef enum logic [1:0] {
        OP_BYTES,
        OP_OPEN,
        OP_CLOSE,
        OP_FAIL
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [1:0]      last_idx;
        logic [3:0][7:0] data;
        logic [3:0]      err;
    } t_cmd;

endpackage

// ===== hdl/json_string_unescape.sv =====
// Path: a pushed word passes the command queue and then the output register to the ports.
// Throughput: one input word per cycle while the command queue has room; the output side
// delivers one result word per cycle while the receiver pops, so a \u escape that
// decodes to N UTF-8 bytes gives N result words, and an opening quote gives none.
// Reset: synchronous, active low; clears decoder state, command queue, UTF-8 check and output.
module json_string_unescape #(
    parameter int CMD_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  jsu_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output jsu_pkg::t_out o_result
);
    import jsu_pkg::*;

    logic accept;
    logic cmd_wr, cmd_full, cmd_valid, cmd_pop;
    t_cmd cmd_in, cmd_head;

    assign accept = push && !cmd_full;
    assign full   = cmd_full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd_valid (cmd_wr),
        .o_cmd       (cmd_in)
    );

    jsu_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_rd    (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_head)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ===== hdl/jsu_front.sv =====
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  jsu_pkg::t_in  i_item,
    output logic          o_cmd_valid,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_BODY    = 3'd1;
    localparam logic [2:0] M_ESC     = 3'd2;
    localparam logic [2:0] M_HEX1    = 3'd3;
    localparam logic [2:0] M_WANT_BS = 3'd4;
    localparam logic [2:0] M_WANT_U  = 3'd5;
    localparam logic [2:0] M_HEX2    = 3'd6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // top six bits of D800..DBFF and DC00..DFFF
    localparam logic [5:0] SUR_HIGH = 6'b110110;
    localparam logic [5:0] SUR_LOW  = 6'b110111;

    function automatic t_cmd fail_cmd(input logic [3:0] code);
        t_cmd c;
        c       = '0;
        c.op    = OP_FAIL;
        c.err   = code;
        return c;
    endfunction

    function automatic t_cmd byte_cmd(input logic [7:0] b);
        t_cmd c;
        c         = '0;
        c.op      = OP_BYTES;
        c.data[0] = b;
        return c;
    endfunction

    function automatic t_cmd utf8_cmd(input logic [20:0] cp);
        t_cmd c;
        c    = '0;
        c.op = OP_BYTES;
        priority if (cp <= 21'h7f) begin
            c.last_idx = 2'd0;
            c.data[0]  = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            c.last_idx = 2'd1;
            c.data[0]  = {3'b110, cp[10:6]};
            c.data[1]  = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            c.last_idx = 2'd2;
            c.data[0]  = {4'b1110, cp[15:12]};
            c.data[1]  = {2'b10, cp[11:6]};
            c.data[2]  = {2'b10, cp[5:0]};
        end else begin
            c.last_idx = 2'd3;
            c.data[0]  = {5'b11110, cp[20:18]};
            c.data[1]  = {2'b10, cp[17:12]};
            c.data[2]  = {2'b10, cp[11:6]};
            c.data[3]  = {2'b10, cp[5:0]};
        end
        return c;
    endfunction

    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_hex_acc, n_hex_acc;
    logic [9:0]  r_hi_bits, n_hi_bits;

    logic [7:0]  b;
    logic [3:0]  digit;
    logic        digit_ok;
    logic [15:0] acc_shift;
    logic [20:0] cp_pair;
    logic        cmd_valid;
    t_cmd        cmd;

    assign b         = i_item.byte_value;
    assign acc_shift = {r_hex_acc[11:0], digit};
    assign cp_pair   = 21'h10000 + {1'b0, r_hi_bits, acc_shift[9:0]};

    always_comb begin
        digit_ok = 1'b1;
        digit    = 4'd0;
        priority if (b >= 8'h30 && b <= 8'h39) begin
            digit = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            digit = b[3:0] + 4'd9;
        end else begin
            digit_ok = 1'b0;
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_hex_acc = r_hex_acc;
        n_hi_bits = r_hi_bits;
        cmd_valid = 1'b0;
        cmd       = byte_cmd(b);
        if (i_item.end_marker) begin
            cmd_valid = 1'b1;
            n_mode    = M_IDLE;
            unique case (r_mode)
                M_IDLE:         cmd = fail_cmd(ERR_NO_QUOTE);
                M_BODY:         cmd = fail_cmd(ERR_UNTERM);
                M_ESC:          cmd = fail_cmd(ERR_SHORT_ESC);
                M_HEX1, M_HEX2: cmd = fail_cmd(ERR_SHORT_HEX);
                default:        cmd = fail_cmd(ERR_NO_LOW);
            endcase
        end else begin
            unique case (r_mode)
                M_IDLE: begin
                    cmd_valid = 1'b1;
                    if (b == CH_QUOTE) begin
                        n_mode    = M_BODY;
                        n_hex_cnt = '0;
                        n_hex_acc = '0;
                        n_hi_bits = '0;
                        cmd       = '0;
                        cmd.op    = OP_OPEN;
                    end else begin
                        cmd = fail_cmd(ERR_NO_QUOTE);
                    end
                end
                M_BODY: begin
                    priority if (b == CH_QUOTE) begin
                        cmd_valid = 1'b1;
                        cmd       = '0;
                        cmd.op    = OP_CLOSE;
                        n_mode    = M_IDLE;
                    end else if (b < 8'h20) begin
                        cmd_valid = 1'b1;
                        cmd       = fail_cmd(ERR_CONTROL);
                        n_mode    = M_IDLE;
                    end else if (b == CH_BSLASH) begin
                        n_mode = M_ESC;
                    end else begin
                        cmd_valid = 1'b1;
                    end
                end
                M_ESC: begin
                    n_mode    = M_BODY;
                    cmd_valid = 1'b1;
                    priority if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH) begin
                        cmd = byte_cmd(b);
                    end else if (b == CH_B) begin
                        cmd = byte_cmd(8'h08);
                    end else if (b == CH_F) begin
                        cmd = byte_cmd(8'h0c);
                    end else if (b == CH_N) begin
                        cmd = byte_cmd(8'h0a);
                    end else if (b == CH_R) begin
                        cmd = byte_cmd(8'h0d);
                    end else if (b == CH_T) begin
                        cmd = byte_cmd(8'h09);
                    end else if (b == CH_U) begin
                        cmd_valid = 1'b0;
                        n_mode    = M_HEX1;
                        n_hex_cnt = '0;
                        n_hex_acc = '0;
                    end else begin
                        cmd    = fail_cmd(ERR_ESCAPE);
                        n_mode = M_IDLE;
                    end
                end
                M_HEX1, M_HEX2: begin
                    if (!digit_ok) begin
                        cmd_valid = 1'b1;
                        cmd       = fail_cmd(ERR_HEX);
                        n_mode    = M_IDLE;
                    end else begin
                        n_hex_acc = acc_shift;
                        if (r_hex_cnt != 2'd3) begin
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else begin
                            n_hex_cnt = '0;
                            if (r_mode == M_HEX1) begin
                                priority if (acc_shift[15:10] == SUR_HIGH) begin
                                    n_hi_bits = acc_shift[9:0];
                                    n_mode    = M_WANT_BS;
                                end else if (acc_shift[15:10] == SUR_LOW) begin
                                    cmd_valid = 1'b1;
                                    cmd       = fail_cmd(ERR_LONE_LOW);
                                    n_mode    = M_IDLE;
                                end else begin
                                    cmd_valid = 1'b1;
                                    cmd       = utf8_cmd({5'd0, acc_shift});
                                    n_mode    = M_BODY;
                                end
                            end else begin
                                cmd_valid = 1'b1;
                                if (acc_shift[15:10] != SUR_LOW) begin
                                    cmd    = fail_cmd(ERR_BAD_LOW);
                                    n_mode = M_IDLE;
                                end else begin
                                    cmd    = utf8_cmd(cp_pair);
                                    n_mode = M_BODY;
                                end
                            end
                        end
                    end
                end
                M_WANT_BS: begin
                    if (b == CH_BSLASH) begin
                        n_mode = M_WANT_U;
                    end else begin
                        cmd_valid = 1'b1;
                        cmd       = fail_cmd(ERR_NO_LOW);
                        n_mode    = M_IDLE;
                    end
                end
                M_WANT_U: begin
                    if (b == CH_U) begin
                        n_mode    = M_HEX2;
                        n_hex_cnt = '0;
                        n_hex_acc = '0;
                    end else begin
                        cmd_valid = 1'b1;
                        cmd       = fail_cmd(ERR_NO_LOW);
                        n_mode    = M_IDLE;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_hex_cnt <= '0;
            r_hex_acc <= '0;
            r_hi_bits <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_hex_acc <= n_hex_acc;
            r_hi_bits <= n_hi_bits;
        end
    end

    assign o_cmd_valid = i_accept & cmd_valid;
    assign o_cmd       = cmd;

endmodule

// ===== hdl/jsu_queue.sv =====
module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  jsu_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output jsu_pkg::t_cmd o_data
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        unique case ({i_wr, i_rd})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= wrap_inc(r_wp);
            end
            if (i_rd) begin
                r_rp <= wrap_inc(r_rp);
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

endmodule

// ===== hdl/jsu_back.sv =====
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output jsu_pkg::t_out o_result
);
    import jsu_pkg::*;

    // continuation byte range after a lead byte
    localparam logic [2:0] RNG_NORM = 3'd0;  // 80..BF
    localparam logic [2:0] RNG_E0   = 3'd1;  // A0..BF
    localparam logic [2:0] RNG_ED   = 3'd2;  // 80..9F
    localparam logic [2:0] RNG_F0   = 3'd3;  // 90..BF
    localparam logic [2:0] RNG_F4   = 3'd4;  // 80..8F

    logic [1:0] r_rem, n_rem, f_rem;
    logic [2:0] r_rng, n_rng, f_rng;
    logic       r_bad, n_bad, f_bad;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out       r_out, word;

    logic       slot_free, issue, produce, is_last;
    logic [7:0] bval, lo, hi;

    assign bval      = i_cmd.data[r_idx];
    assign is_last   = (r_idx == i_cmd.last_idx);
    assign slot_free = !r_out_valid || i_pop;
    assign issue     = i_cmd_valid && (i_cmd.op == OP_OPEN || slot_free);
    assign produce   = issue && (i_cmd.op != OP_OPEN);

    // streaming validator step for one decoded byte
    always_comb begin
        f_rem = r_rem;
        f_rng = r_rng;
        f_bad = r_bad;
        lo    = 8'h80;
        hi    = 8'hbf;
        unique case (r_rng)
            RNG_E0:  lo = 8'ha0;
            RNG_ED:  hi = 8'h9f;
            RNG_F0:  lo = 8'h90;
            RNG_F4:  hi = 8'h8f;
            default: ;
        endcase
        if (!r_bad) begin
            if (r_rem != 2'd0) begin
                if (bval < lo || bval > hi) begin
                    f_bad = 1'b1;
                    f_rem = 2'd0;
                end else begin
                    f_rem = r_rem - 2'd1;
                    f_rng = RNG_NORM;
                end
            end else begin
                f_rng = RNG_NORM;
                priority if (bval < 8'h80) begin
                    f_rem = 2'd0;
                end else if (bval >= 8'hc2 && bval <= 8'hdf) begin
                    f_rem = 2'd1;
                end else if (bval >= 8'he0 && bval <= 8'hef) begin
                    f_rem = 2'd2;
                    if (bval == 8'he0) begin
                        f_rng = RNG_E0;
                    end else if (bval == 8'hed) begin
                        f_rng = RNG_ED;
                    end
                end else if (bval >= 8'hf0 && bval <= 8'hf4) begin
                    f_rem = 2'd3;
                    if (bval == 8'hf0) begin
                        f_rng = RNG_F0;
                    end else if (bval == 8'hf4) begin
                        f_rng = RNG_F4;
                    end
                end else begin
                    f_bad = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_rem     = r_rem;
        n_rng     = r_rng;
        n_bad     = r_bad;
        n_idx     = r_idx;
        o_cmd_pop = 1'b0;
        word      = '0;
        if (issue) begin
            unique case (i_cmd.op)
                OP_OPEN: begin
                    n_rem     = 2'd0;
                    n_rng     = RNG_NORM;
                    n_bad     = 1'b0;
                    o_cmd_pop = 1'b1;
                end
                OP_BYTES: begin
                    word.out_byte = bval;
                    word.kind     = KIND_BYTE;
                    word.last     = is_last;
                    n_rem         = f_rem;
                    n_rng         = f_rng;
                    n_bad         = f_bad;
                    o_cmd_pop     = is_last;
                    n_idx         = is_last ? 2'd0 : r_idx + 2'd1;
                end
                OP_CLOSE: begin
                    if (r_bad || r_rem != 2'd0) begin
                        word.kind       = KIND_ERR;
                        word.error_code = ERR_UTF8;
                    end else begin
                        word.kind       = KIND_DONE;
                        word.error_code = ERR_NONE;
                    end
                    word.last = 1'b1;
                    o_cmd_pop = 1'b1;
                end
                OP_FAIL: begin
                    word.kind       = KIND_ERR;
                    word.error_code = i_cmd.err;
                    word.last       = 1'b1;
                    o_cmd_pop       = 1'b1;
                end
                default: ;
            endcase
        end
        n_out_valid = produce ? 1'b1 : (r_out_valid && !i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= 2'd0;
            r_rng       <= RNG_NORM;
            r_bad       <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_rem       <= n_rem;
            r_rng       <= n_rng;
            r_bad       <= n_bad;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out <= word;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/jsu_checker.sv =====
module jsu_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input jsu_pkg::t_out o_result
);
    import jsu_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("queue not clear after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.kind == KIND_BYTE || o_result.kind == KIND_DONE ||
                    o_result.kind == KIND_ERR))
        else $error("illegal result kind");

    a_code_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind != KIND_ERR) |-> (o_result.error_code == ERR_NONE))
        else $error("error code on non-error result");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind != KIND_BYTE) |-> o_result.last)
        else $error("done or error word not marked last");

endmodule

bind json_string_unescape jsu_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 3;
    localparam int PHASE_WORDS    = 95;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 16;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = "u";

    typedef enum logic [2:0] {
        MD_IDLE, MD_BODY, MD_ESC, MD_HEX1, MD_WANT_BS, MD_WANT_U, MD_HEX2
    } t_mode;

    // allowed range of the next UTF-8 continuation byte
    typedef enum logic [2:0] {
        RNG_80_BF, RNG_A0_BF, RNG_80_9F, RNG_90_BF, RNG_80_8F
    } t_range;

    typedef enum int {
        F_NONE, F_RAW_ANY, F_CONTROL, F_BAD_ESC, F_BAD_HEX, F_NO_LOW, F_BAD_LOW,
        F_LONE_LOW, F_BAD_UTF8, F_END_BODY, F_END_ESC, F_END_HEX, F_END_NO_LOW
    } t_fault;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  push    = 1'b0;
    logic  pop     = 1'b0;
    t_in   i_item  = '0;
    logic  full;
    logic  empty;
    t_out  o_result;

    json_string_unescape i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_in   raw_q[$];          // raw JSON words waiting to be pushed
    t_out  unescaped_q[$];    // decoded words still expected from the block
    t_out  step_res[$];
    t_out  want;

    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    hold_reqs = 0;
    int    hold_seen = 0;
    int    hold_left = 0;
    int    stall_cycles = 0;
    int    n_fail = 0;
    int    n_in = 0;
    int    n_out = 0;
    int    n_done = 0;
    int    n_err = 0;
    int    n_strings = 0;
    logic [15:0] err_seen = '0;

    // decoder state of the predictor
    t_mode       dec_mode = MD_IDLE;
    logic [1:0]  hex_cnt  = '0;
    logic [15:0] hex_acc  = '0;
    logic [9:0]  hi_bits  = '0;
    logic [1:0]  u8_left  = '0;
    t_range      u8_range = RNG_80_BF;
    logic        u8_bad   = 1'b0;

    function automatic int hex_val(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    task automatic u8_track(logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (u8_bad) return;
        if (u8_left != 0) begin
            case (u8_range)
                RNG_A0_BF: lo = 8'hA0;
                RNG_80_9F: hi = 8'h9F;
                RNG_90_BF: lo = 8'h90;
                RNG_80_8F: hi = 8'h8F;
                default: ;
            endcase
            if (b < lo || b > hi) begin
                u8_bad = 1'b1;
                u8_left = '0;
            end else begin
                u8_left = u8_left - 2'd1;
                u8_range = RNG_80_BF;
            end
            return;
        end
        u8_range = RNG_80_BF;
        if (b < 8'h80) return;
        if (b >= 8'hC2 && b <= 8'hDF) begin
            u8_left = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            u8_left = 2'd2;
            if (b == 8'hE0) u8_range = RNG_A0_BF;
            else if (b == 8'hED) u8_range = RNG_80_9F;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            u8_left = 2'd3;
            if (b == 8'hF0) u8_range = RNG_90_BF;
            else if (b == 8'hF4) u8_range = RNG_80_8F;
        end else begin
            u8_bad = 1'b1;
        end
    endtask

    task automatic put_result(logic [7:0] b, logic [1:0] k, logic [3:0] e);
        step_res.insert(step_res.size(),
                        t_out'{out_byte: b, kind: k, error_code: e, last: 1'b0});
    endtask

    task automatic put_byte(logic [7:0] b);
        u8_track(b);
        put_result(b, KIND_BYTE, ERR_NONE);
    endtask

    task automatic fail_with(logic [3:0] e);
        put_result(8'h00, KIND_ERR, e);
        dec_mode = MD_IDLE;
    endtask

    task automatic put_cp(logic [20:0] cp);
        if (cp <= 21'h7F) begin
            put_byte(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endtask

    // predicts the result words of one accepted raw word
    task automatic unescape_word(t_in w);
        logic [7:0]  b;
        logic [15:0] v;
        int          d;
        t_out        r;
        b = w.byte_value;
        step_res.delete();
        if (w.end_marker) begin
            case (dec_mode)
                MD_IDLE:          fail_with(ERR_NO_QUOTE);
                MD_BODY:          fail_with(ERR_UNTERM);
                MD_ESC:           fail_with(ERR_SHORT_ESC);
                MD_HEX1, MD_HEX2: fail_with(ERR_SHORT_HEX);
                default:          fail_with(ERR_NO_LOW);
            endcase
        end else begin
            case (dec_mode)
                MD_IDLE: begin
                    if (b == CH_QUOTE) begin
                        hex_cnt = '0;
                        hex_acc = '0;
                        hi_bits = '0;
                        u8_left = '0;
                        u8_range = RNG_80_BF;
                        u8_bad = 1'b0;
                        dec_mode = MD_BODY;
                    end else begin
                        fail_with(ERR_NO_QUOTE);
                    end
                end
                MD_BODY: begin
                    if (b == CH_QUOTE) begin
                        if (u8_bad || u8_left != 0) begin
                            fail_with(ERR_UTF8);
                        end else begin
                            put_result(8'h00, KIND_DONE, ERR_NONE);
                            dec_mode = MD_IDLE;
                        end
                    end else if (b < 8'h20) begin
                        fail_with(ERR_CONTROL);
                    end else if (b == CH_BSLASH) begin
                        dec_mode = MD_ESC;
                    end else begin
                        put_byte(b);
                    end
                end
                MD_ESC: begin
                    dec_mode = MD_BODY;
                    case (b)
                        CH_QUOTE, CH_BSLASH, "/": put_byte(b);
                        "b": put_byte(8'h08);
                        "f": put_byte(8'h0C);
                        "n": put_byte(8'h0A);
                        "r": put_byte(8'h0D);
                        "t": put_byte(8'h09);
                        CH_U: begin
                            dec_mode = MD_HEX1;
                            hex_cnt = '0;
                            hex_acc = '0;
                        end
                        default: fail_with(ERR_ESCAPE);
                    endcase
                end
                MD_HEX1, MD_HEX2: begin
                    d = hex_val(b);
                    if (d < 0) begin
                        fail_with(ERR_HEX);
                    end else begin
                        hex_acc = {hex_acc[11:0], d[3:0]};
                        if (hex_cnt != 2'd3) begin
                            hex_cnt = hex_cnt + 2'd1;
                        end else begin
                            hex_cnt = '0;
                            v = hex_acc;
                            if (dec_mode == MD_HEX1) begin
                                if (v >= 16'hD800 && v <= 16'hDBFF) begin
                                    hi_bits = v[9:0];
                                    dec_mode = MD_WANT_BS;
                                end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                                    fail_with(ERR_LONE_LOW);
                                end else begin
                                    put_cp({5'd0, v});
                                    dec_mode = MD_BODY;
                                end
                            end else if (v < 16'hDC00 || v > 16'hDFFF) begin
                                fail_with(ERR_BAD_LOW);
                            end else begin
                                put_cp(21'h10000 + {1'b0, hi_bits, v[9:0]});
                                dec_mode = MD_BODY;
                            end
                        end
                    end
                end
                MD_WANT_BS: begin
                    if (b == CH_BSLASH) dec_mode = MD_WANT_U;
                    else fail_with(ERR_NO_LOW);
                end
                MD_WANT_U: begin
                    if (b == CH_U) begin
                        dec_mode = MD_HEX2;
                        hex_cnt = '0;
                        hex_acc = '0;
                    end else begin
                        fail_with(ERR_NO_LOW);
                    end
                end
                default: dec_mode = MD_IDLE;
            endcase
        end
        foreach (step_res[i]) begin
            r = step_res[i];
            r.last = (i == step_res.size() - 1);
            unescaped_q.insert(unescaped_q.size(), r);
        end
    endtask

    // ---------------- stimulus helpers ----------------

    task automatic add_byte(logic [7:0] b);
        raw_q.insert(raw_q.size(), t_in'{byte_value: b, end_marker: 1'b0});
    endtask

    task automatic add_end();
        raw_q.insert(raw_q.size(), t_in'{byte_value: 8'($urandom), end_marker: 1'b1});
    endtask

    function automatic logic [7:0] byte_in(logic [7:0] lo, logic [7:0] hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return "0" + 8'(n);
        if ($urandom_range(0, 1) != 0) return "a" + 8'(n - 10);
        return "A" + 8'(n - 10);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = byte_in(8'h20, 8'h7E); while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic bit is_esc_letter(logic [7:0] b);
        case (b)
            CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", CH_U: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] simple_esc(int k);
        case (k)
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return "/";
            3: return "b";
            4: return "f";
            5: return "n";
            6: return "r";
            default: return "t";
        endcase
    endfunction

    function automatic logic [15:0] high_sur();
        case ($urandom_range(0, 3))
            0: return 16'hD800;
            1: return 16'hDBFF;
            default: return 16'hD800 + 16'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [15:0] low_sur();
        case ($urandom_range(0, 3))
            0: return 16'hDC00;
            1: return 16'hDFFF;
            default: return 16'hDC00 + 16'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [15:0] bmp_value();
        logic [15:0] v;
        case ($urandom_range(0, 4))
            0: v = 16'($urandom_range(0, 16'h7F));
            1: v = 16'($urandom_range(16'h80, 16'h7FF));
            2: begin
                v = 16'($urandom_range(16'h800, 16'hFFFF));
                if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h4000;
            end
            default: begin
                case ($urandom_range(0, 7))
                    0: v = 16'h0000;
                    1: v = 16'h007F;
                    2: v = 16'h0080;
                    3: v = 16'h07FF;
                    4: v = 16'h0800;
                    5: v = 16'hD7FF;
                    6: v = 16'hE000;
                    default: v = 16'hFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_esc_u(logic [15:0] v);
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
    endtask

    task automatic add_raw_utf8();
        logic [7:0] lead;
        case ($urandom_range(0, 2))
            0: begin
                add_byte(byte_in(8'hC2, 8'hDF));
                add_byte(byte_in(8'h80, 8'hBF));
            end
            1: begin
                lead = byte_in(8'hE0, 8'hEF);
                add_byte(lead);
                if (lead == 8'hE0) add_byte(byte_in(8'hA0, 8'hBF));
                else if (lead == 8'hED) add_byte(byte_in(8'h80, 8'h9F));
                else add_byte(byte_in(8'h80, 8'hBF));
                add_byte(byte_in(8'h80, 8'hBF));
            end
            default: begin
                lead = byte_in(8'hF0, 8'hF4);
                add_byte(lead);
                if (lead == 8'hF0) add_byte(byte_in(8'h90, 8'hBF));
                else if (lead == 8'hF4) add_byte(byte_in(8'h80, 8'h8F));
                else add_byte(byte_in(8'h80, 8'hBF));
                repeat (2) add_byte(byte_in(8'h80, 8'hBF));
            end
        endcase
    endtask

    task automatic add_segment();
        case ($urandom_range(0, 4))
            0: repeat ($urandom_range(1, 4)) add_byte(plain_char());
            1: add_raw_utf8();
            2: begin
                add_byte(CH_BSLASH);
                add_byte(simple_esc($urandom_range(0, 7)));
            end
            3: add_esc_u(bmp_value());
            default: begin
                add_esc_u(high_sur());
                add_esc_u(low_sur());
            end
        endcase
    endtask

    // alive stays set when the string body goes on after the fault
    task automatic add_fault(t_fault f, output bit alive);
        logic [7:0]  b;
        logic [15:0] v;
        alive = 1'b0;
        case (f)
            F_RAW_ANY: begin
                add_byte(8'($urandom));
                alive = 1'b1;
            end
            F_CONTROL: add_byte(byte_in(8'h00, 8'h1F));
            F_BAD_ESC: begin
                do b = 8'($urandom); while (is_esc_letter(b));
                add_byte(CH_BSLASH);
                add_byte(b);
            end
            F_BAD_HEX, F_END_HEX: begin
                if ($urandom_range(0, 1) != 0) add_esc_u(high_sur());
                add_byte(CH_BSLASH);
                add_byte(CH_U);
                repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom)));
                if (f == F_BAD_HEX) begin
                    do b = 8'($urandom); while (hex_val(b) >= 0);
                    add_byte(b);
                end else begin
                    add_end();
                end
            end
            F_NO_LOW: begin
                add_esc_u(high_sur());
                if ($urandom_range(0, 1) != 0) begin
                    do b = 8'($urandom); while (b == CH_BSLASH);
                    add_byte(b);
                end else begin
                    do b = 8'($urandom); while (b == CH_U);
                    add_byte(CH_BSLASH);
                    add_byte(b);
                end
            end
            F_BAD_LOW: begin
                add_esc_u(high_sur());
                do v = 16'($urandom); while (v >= 16'hDC00 && v <= 16'hDFFF);
                add_esc_u(v);
            end
            F_LONE_LOW: add_esc_u(low_sur());
            F_BAD_UTF8: begin
                case ($urandom_range(0, 6))
                    0: add_byte(byte_in(8'h80, 8'hC1));
                    1: add_byte(byte_in(8'hF5, 8'hFF));
                    2: begin add_byte(8'hE0); add_byte(byte_in(8'h80, 8'h9F)); end
                    3: begin add_byte(8'hED); add_byte(byte_in(8'hA0, 8'hBF)); end
                    4: begin add_byte(8'hF0); add_byte(byte_in(8'h80, 8'h8F)); end
                    5: begin add_byte(8'hF4); add_byte(byte_in(8'h90, 8'hBF)); end
                    default: add_byte(byte_in(8'hC2, 8'hF4));    // truncated sequence
                endcase
                alive = 1'b1;
            end
            F_END_BODY: add_end();
            F_END_ESC: begin
                add_byte(CH_BSLASH);
                add_end();
            end
            default: begin
                add_esc_u(high_sur());
                if ($urandom_range(0, 1) != 0) add_byte(CH_BSLASH);
                add_end();
            end
        endcase
    endtask

    task automatic add_string();
        int     nseg;
        int     at;
        t_fault f;
        bit     alive;
        nseg = $urandom_range(0, 6);
        at = $urandom_range(0, nseg);
        f = ($urandom_range(0, 99) < 30) ? t_fault'($urandom_range(1, 12)) : F_NONE;
        alive = 1'b1;
        n_strings++;
        add_byte(CH_QUOTE);
        for (int s = 0; s <= nseg && alive; s++) begin
            if (f != F_NONE && s == at) add_fault(f, alive);
            if (s < nseg && alive) add_segment();
        end
        if (alive) add_byte(CH_QUOTE);
    endtask

    // junk between strings
    task automatic add_noise();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            add_end();
        end else begin
            do b = 8'($urandom); while (b == CH_QUOTE);
            add_byte(b);
        end
    endtask

    task automatic wait_drain();
        while (raw_q.size() != 0) @(negedge i_clk);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                unescape_word(i_item);
                void'(raw_q.pop_front());
                n_in++;
            end
            if (!(push && full)) begin
                if (raw_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    push <= 1'b1;
                    i_item <= raw_q[0];
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                n_out++;
                if (o_result.kind == KIND_DONE) n_done++;
                if (o_result.kind == KIND_ERR) begin
                    n_err++;
                    err_seen[o_result.error_code] = 1'b1;
                end
                if (unescaped_q.size() == 0) begin
                    $error("unexpected result word %p", o_result);
                    n_fail++;
                end else begin
                    want = unescaped_q.pop_front();
                    if (o_result.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, o_result.out_byte);
                        n_fail++;
                    end
                    if (o_result.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, o_result.kind);
                        n_fail++;
                    end
                    if (o_result.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, o_result.error_code);
                        n_fail++;
                    end
                    if (o_result.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, o_result.last);
                        n_fail++;
                    end
                end
            end
            if (hold_seen != hold_reqs) begin
                hold_seen <= hold_reqs;
                hold_left <= HOLD_CYCLES;
                pop <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (stall_cycles < WATCHDOG_LIMIT);
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_byte(8'hFF);                                        // idle, no quote
        add_end();                                              // idle, end of input
        add_byte(CH_QUOTE); add_byte(8'h00);                    // raw control byte
        add_byte(CH_QUOTE); add_byte(CH_BSLASH); add_byte("q"); // unknown escape
        add_byte(CH_QUOTE); add_byte(CH_BSLASH); add_byte(CH_U);
        add_byte("1"); add_byte("G");                           // bad hex digit
        add_byte(CH_QUOTE); add_esc_u(16'hDBFF); add_byte("x"); // high without low
        add_byte(CH_QUOTE); add_esc_u(16'hDC00);                // lone low
        add_byte(CH_QUOTE); add_end();                          // unterminated
        add_byte(CH_QUOTE); add_byte(CH_BSLASH); add_end();     // end after backslash
        wait_drain();

        // long string while the receiver holds off, so the block backs up
        add_byte(CH_QUOTE);
        repeat (40) add_byte(plain_char());
        add_byte(CH_QUOTE);
        hold_reqs++;
        wait_drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            while (raw_q.size() < PHASE_WORDS) begin
                if ($urandom_range(0, 9) == 0) add_noise();
                else add_string();
            end
            wait_drain();
        end

        recv_stall_pct = 0;
        while (unescaped_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d raw words over %0d random strings, %0d result words checked",
                 n_in, n_strings, n_out);
        $display("%0d strings closed cleanly, %0d error words, error codes seen %b",
                 n_done, n_err, err_seen);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape.sv
hdl/jsu_checker.sv
verif/tb.sv
